FILE: hdl/bce_pkg.sv
// Shared types, codes and polymod helpers for the bech32 checksum engine.
package bce_pkg;

    // Default capacity of the hrp low-part store
    localparam int HRP_MAX_DEF = 64;

    // Request codes on s_req_type
    localparam logic [1:0] REQ_HRP    = 2'd0;
    localparam logic [1:0] REQ_DATA   = 2'd1;
    localparam logic [1:0] REQ_CREATE = 2'd2;
    localparam logic [1:0] REQ_VERIFY = 2'd3;

    // Status codes on m_status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;
    localparam logic [1:0] ST_SEQ_ERR  = 2'd3;

    // BCH generator terms
    localparam logic [29:0] GEN0 = 30'h3b6a57b2;
    localparam logic [29:0] GEN1 = 30'h26508e6d;
    localparam logic [29:0] GEN2 = 30'h1ea119fa;
    localparam logic [29:0] GEN3 = 30'h3d4233dd;
    localparam logic [29:0] GEN4 = 30'h2a1462b3;

    localparam logic [29:0] CHK_INIT = 30'd1;
    localparam logic [2:0]  CNT_MAX  = 3'd7;
    localparam logic [2:0]  MIN_DATA = 3'd6;
    localparam logic [2:0]  SYM_LAST = 3'd5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic hrp_op;      // fold high bits of s_value, store low bits
        logic sym_now;     // fold s_value data symbol directly
        logic latch;       // capture the request word
        logic fold_zero;   // fold a zero symbol
        logic ptr_clear;   // restart the store walk
        logic flush_step;  // fold the stored low part, advance
        logic set_phase;   // enter the data phase
        logic held_sym;    // fold the captured data symbol
        logic step_clear;
        logic step_inc;
        logic emit;        // load the result register
        logic clear_all;   // return state to reset values
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic phase;
        logic seq_err;
        logic flush_done;
        logic held_data;
        logic step_last;
        logic emit_last;
        logic out_free;
    } sts_t;

    // One polymod step
    function automatic logic [29:0] fold(input logic [29:0] chk, input logic [4:0] sym);
        logic [4:0]  top;
        logic [29:0] nxt;
        top = chk[29:25];
        nxt = {chk[24:0], 5'b0} ^ {25'b0, sym};
        if (top[0]) nxt = nxt ^ GEN0;
        if (top[1]) nxt = nxt ^ GEN1;
        if (top[2]) nxt = nxt ^ GEN2;
        if (top[3]) nxt = nxt ^ GEN3;
        if (top[4]) nxt = nxt ^ GEN4;
        return nxt;
    endfunction

    // Lowercase charset character of a symbol
    function automatic logic [6:0] charset(input logic [4:0] sym);
        logic [6:0] c;
        case (sym)
            5'd0:  c = 7'h71; // q
            5'd1:  c = 7'h70; // p
            5'd2:  c = 7'h7a; // z
            5'd3:  c = 7'h72; // r
            5'd4:  c = 7'h79; // y
            5'd5:  c = 7'h39; // 9
            5'd6:  c = 7'h78; // x
            5'd7:  c = 7'h38; // 8
            5'd8:  c = 7'h67; // g
            5'd9:  c = 7'h66; // f
            5'd10: c = 7'h32; // 2
            5'd11: c = 7'h74; // t
            5'd12: c = 7'h76; // v
            5'd13: c = 7'h64; // d
            5'd14: c = 7'h77; // w
            5'd15: c = 7'h30; // 0
            5'd16: c = 7'h73; // s
            5'd17: c = 7'h33; // 3
            5'd18: c = 7'h6a; // j
            5'd19: c = 7'h6e; // n
            5'd20: c = 7'h35; // 5
            5'd21: c = 7'h34; // 4
            5'd22: c = 7'h6b; // k
            5'd23: c = 7'h68; // h
            5'd24: c = 7'h63; // c
            5'd25: c = 7'h65; // e
            5'd26: c = 7'h36; // 6
            5'd27: c = 7'h6d; // m
            5'd28: c = 7'h75; // u
            5'd29: c = 7'h61; // a
            5'd30: c = 7'h37; // 7
            5'd31: c = 7'h6c; // l
            default: c = 7'h71;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/bce_ctrl.sv
// Sequencing state machine of the bech32 checksum engine.
module bce_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  bce_pkg::sts_t    sts,
    output bce_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FZERO = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_CFOLD = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       create_go;

    assign s_ready = (state_reg == S_IDLE);

    // Create folds six zeros only when no sequence error was flagged
    assign create_go = (s_req_type == bce_pkg::REQ_CREATE) && !sts.seq_err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode the next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_req_type)
                        bce_pkg::REQ_HRP: begin
                            cmd.hrp_op = 1'b1;
                        end
                        bce_pkg::REQ_DATA: begin
                            if (sts.phase) begin
                                cmd.sym_now = 1'b1;
                            end else begin
                                cmd.latch  = 1'b1;
                                state_next = S_FZERO;
                            end
                        end
                        default: begin
                            cmd.latch      = 1'b1;
                            cmd.step_clear = 1'b1;
                            if (!sts.phase) begin
                                state_next = S_FZERO;
                            end else if (create_go) begin
                                state_next = S_CFOLD;
                            end else begin
                                state_next = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            S_FZERO: begin
                cmd.fold_zero = 1'b1;
                cmd.ptr_clear = 1'b1;
                state_next    = S_FLUSH;
            end
            S_FLUSH: begin
                if (sts.flush_done) begin
                    cmd.set_phase = 1'b1;
                    if (sts.held_data) begin
                        cmd.held_sym = 1'b1;
                        state_next   = S_IDLE;
                    end else if (!sts.emit_last) begin
                        state_next = S_CFOLD;
                    end else begin
                        state_next = S_EMIT;
                    end
                end else begin
                    cmd.flush_step = 1'b1;
                end
            end
            S_CFOLD: begin
                cmd.fold_zero = 1'b1;
                if (sts.step_last) begin
                    cmd.step_clear = 1'b1;
                    state_next     = S_EMIT;
                end else begin
                    cmd.step_inc = 1'b1;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.step_inc = 1'b1;
                    if (sts.emit_last) begin
                        cmd.clear_all = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/bce_dp.sv
// Polymod register, hrp low-part store, counters and result register.
module bce_dp #(
    parameter int HRP_MAX = bce_pkg::HRP_MAX_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    s_req_type,
    input  logic [7:0]    s_value,
    input  bce_pkg::cmd_t cmd,
    output bce_pkg::sts_t sts,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [4:0]    m_symbol,
    output logic [6:0]    m_symbol_char,
    output logic [1:0]    m_status,
    output logic          m_last
);

    localparam int LEN_W = $clog2(HRP_MAX + 1);
    localparam int IDX_W = (HRP_MAX > 1) ? $clog2(HRP_MAX) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(HRP_MAX);

    logic [4:0]       store_mem [HRP_MAX];
    logic [29:0]      chk_reg, chk_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] ptr_reg, ptr_next;
    logic             phase_reg, phase_next;
    logic [2:0]       count_reg, count_next;
    logic             seq_reg, seq_next;
    logic [2:0]       step_reg, step_next;
    logic [1:0]       held_req_reg;
    logic [4:0]       held_val_reg;
    logic [4:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             hrp_reject;
    logic             sym_fold;
    logic             create_ok;
    logic [29:0]      final_chk;
    logic [4:0]       shift_amt;
    logic [4:0]       out_sym;
    logic             m_valid_reg;
    logic [4:0]       m_symbol_reg;
    logic [6:0]       m_symbol_char_reg;
    logic [1:0]       m_status_reg;
    logic             m_last_reg;
    logic [1:0]       verify_status;

    assign hrp_reject = phase_reg || (len_reg >= LEN_MAX);
    assign sym_fold   = cmd.sym_now || cmd.held_sym;
    assign create_ok  = (held_req_reg == bce_pkg::REQ_CREATE) && !seq_reg;

    // Next polymod value
    always_comb begin
        chk_next = chk_reg;
        if (cmd.clear_all) begin
            chk_next = bce_pkg::CHK_INIT;
        end else if (cmd.hrp_op && !hrp_reject) begin
            chk_next = bce_pkg::fold(chk_reg, {2'b0, s_value[7:5]});
        end else if (cmd.sym_now) begin
            chk_next = bce_pkg::fold(chk_reg, s_value[4:0]);
        end else if (cmd.fold_zero) begin
            chk_next = bce_pkg::fold(chk_reg, 5'd0);
        end else if (cmd.flush_step) begin
            chk_next = bce_pkg::fold(chk_reg, rd_data_reg);
        end else if (cmd.held_sym) begin
            chk_next = bce_pkg::fold(chk_reg, held_val_reg);
        end
    end

    // Message bookkeeping
    always_comb begin
        len_next   = len_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        seq_next   = seq_reg;
        if (cmd.clear_all) begin
            len_next   = '0;
            phase_next = 1'b0;
            count_next = '0;
            seq_next   = 1'b0;
        end else begin
            if (cmd.hrp_op) begin
                if (hrp_reject) begin
                    seq_next = 1'b1;
                end else begin
                    len_next = len_reg + 1'b1;
                end
            end
            if (cmd.set_phase) begin
                phase_next = 1'b1;
            end
            if (sym_fold && (count_reg != bce_pkg::CNT_MAX)) begin
                count_next = count_reg + 3'd1;
            end
        end
    end

    // Store walk pointer and result step counter
    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_clear) begin
            ptr_next = '0;
        end else if (cmd.flush_step) begin
            ptr_next = ptr_reg + 1'b1;
        end
        step_next = step_reg;
        if (cmd.step_clear) begin
            step_next = '0;
        end else if (cmd.step_inc) begin
            step_next = step_reg + 3'd1;
        end
    end

    assign rd_addr = (ptr_next < LEN_MAX) ? ptr_next[IDX_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_reg   <= bce_pkg::CHK_INIT;
            len_reg   <= '0;
            phase_reg <= 1'b0;
            count_reg <= '0;
            seq_reg   <= 1'b0;
            ptr_reg   <= '0;
            step_reg  <= '0;
        end else begin
            chk_reg   <= chk_next;
            len_reg   <= len_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
            ptr_reg   <= ptr_next;
            step_reg  <= step_next;
        end
    end

    // Capture the request word awaiting the flush or the finish
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            held_req_reg <= s_req_type;
            held_val_reg <= s_value[4:0];
        end
    end

    // Hrp low-part store: write on accepted hrp word, registered read
    always_ff @(posedge aclk) begin
        if (cmd.hrp_op && !hrp_reject) begin
            store_mem[len_reg[IDX_W-1:0]] <= s_value[4:0];
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Result word contents
    assign final_chk = chk_reg ^ bce_pkg::CHK_INIT;
    assign shift_amt = 5'd25 - 5'(step_reg) * 5'd5;
    assign out_sym   = final_chk[shift_amt +: 5];

    always_comb begin
        if (seq_reg) begin
            verify_status = bce_pkg::ST_SEQ_ERR;
        end else if (count_reg < bce_pkg::MIN_DATA) begin
            verify_status = bce_pkg::ST_SHORT;
        end else if (chk_reg != bce_pkg::CHK_INIT) begin
            verify_status = bce_pkg::ST_MISMATCH;
        end else begin
            verify_status = bce_pkg::ST_OK;
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (create_ok) begin
                m_symbol_reg      <= out_sym;
                m_symbol_char_reg <= bce_pkg::charset(out_sym);
                m_status_reg      <= bce_pkg::ST_OK;
                m_last_reg        <= (step_reg == bce_pkg::SYM_LAST);
            end else begin
                m_symbol_reg      <= '0;
                m_symbol_char_reg <= '0;
                m_status_reg      <= (held_req_reg == bce_pkg::REQ_CREATE) ?
                                     bce_pkg::ST_SEQ_ERR : verify_status;
                m_last_reg        <= 1'b1;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_symbol      = m_symbol_reg;
    assign m_symbol_char = m_symbol_char_reg;
    assign m_status      = m_status_reg;
    assign m_last        = m_last_reg;

    // Status to the controller
    always_comb begin
        sts            = '0;
        sts.phase      = phase_reg;
        sts.seq_err    = seq_reg;
        sts.flush_done = (ptr_reg == len_reg);
        sts.held_data  = (held_req_reg == bce_pkg::REQ_DATA);
        sts.step_last  = (step_reg == bce_pkg::SYM_LAST);
        sts.emit_last  = !create_ok || (step_reg == bce_pkg::SYM_LAST);
        sts.out_free   = !m_valid_reg || m_ready;
    end

endmodule

FILE: hdl/bech32_checksum_engine.sv
// Top level of the bech32 checksum engine: controller plus datapath.
//
//   Channel  Ports                                        Direction
//   s_       s_valid s_ready s_req_type s_value           in
//   m_       m_valid m_ready m_symbol m_symbol_char       out
//            m_status m_last
//
// Hrp words and data words in the data phase are folded as they are taken.
// The first data word or finish folds a zero, then the stored hrp low parts
// one per cycle. Create folds six zeros and gives six result words
// (one on a sequence error); verify gives one.
// Reset is synchronous, active low; the store needs no clearing pass.
// s_ready falls during a flush or finish; hrp and data words are still taken
// while an earlier result word waits on m_ready.
module bech32_checksum_engine #(
    parameter int HRP_MAX = bce_pkg::HRP_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_symbol,
    output logic [6:0] m_symbol_char,
    output logic [1:0] m_status,
    output logic       m_last
);

    bce_pkg::cmd_t cmd;
    bce_pkg::sts_t sts;

    bce_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .sts        (sts),
        .cmd        (cmd)
    );

    bce_dp #(
        .HRP_MAX (HRP_MAX)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_req_type    (s_req_type),
        .s_value       (s_value),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_symbol_char (m_symbol_char),
        .m_status      (m_status),
        .m_last        (m_last)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the bech32 checksum engine.
`timescale 1ns / 1ps

module tb_top;

    localparam int  HRP_CAP       = bce_pkg::HRP_MAX_DEF;
    localparam int  LOW_IDX_W     = $clog2(HRP_CAP);
    localparam int  TOTAL_WORDS   = 130;
    localparam int  DRAIN_CYCLES  = 100;
    localparam int  CYCLE_LIMIT   = 300000;
    localparam int  HOLD_CYCLES   = 400;

    // BCH generator terms, index 0 for the lowest top bit
    localparam logic [4:0][29:0] GEN_TERMS = {bce_pkg::GEN4, bce_pkg::GEN3, bce_pkg::GEN2,
                                              bce_pkg::GEN1, bce_pkg::GEN0};
    // Charset letters, symbol 0 in the top byte
    localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef struct packed {
        logic [4:0] symbol;
        logic [6:0] symbol_char;
        logic [1:0] status;
        logic       last;
    } result_word_t;

    typedef logic [7:0] byte_q_t[$];

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_req_type;
    logic [7:0] s_value;
    logic       m_valid;
    logic       m_ready;
    logic [4:0] m_symbol;
    logic [6:0] m_symbol_char;
    logic [1:0] m_status;
    logic       m_last;

    // Shadow of the engine state
    logic [29:0] poly_acc;
    logic [4:0]  hrp_lows [HRP_CAP];
    logic [6:0]  hrp_len;
    logic        in_data;
    logic [2:0]  data_cnt;
    logic        seq_fault;

    result_word_t pending_words[$];
    int mismatch_count;
    int words_sent;
    int cycle_count;
    int rx_hold_left;
    bit tx_gaps_on;
    bit rx_stall_on;

    bech32_checksum_engine uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_symbol_char (m_symbol_char),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [29:0] polymod_step(input logic [29:0] acc,
                                                 input logic [4:0] sym);
        logic [29:0] nxt;
        nxt = {acc[24:0], sym};
        for (int b = 0; b < 5; b++) begin
            if (acc[25 + b]) nxt = nxt ^ GEN_TERMS[b];
        end
        return nxt;
    endfunction

    function automatic logic [6:0] symbol_letter(input logic [4:0] sym);
        logic [7:0] letter;
        letter = ALPHABET[8 * (31 - sym) +: 8];
        return letter[6:0];
    endfunction

    task automatic clear_shadow();
        poly_acc  = bce_pkg::CHK_INIT;
        hrp_len   = '0;
        in_data   = 1'b0;
        data_cnt  = '0;
        seq_fault = 1'b0;
    endtask

    // Fold the separator zero and the kept hrp low parts, once per message
    task automatic flush_hrp_lows();
        if (!in_data) begin
            poly_acc = polymod_step(poly_acc, 5'd0);
            for (int i = 0; i < hrp_len; i++)
                poly_acc = polymod_step(poly_acc, hrp_lows[i]);
            in_data = 1'b1;
        end
    endtask

    task automatic push_result(input logic [4:0] sym, input logic [6:0] ch,
                               input logic [1:0] st, input logic lst);
        result_word_t w;
        w.symbol      = sym;
        w.symbol_char = ch;
        w.status      = st;
        w.last        = lst;
        pending_words.insert(pending_words.size(), w);
    endtask

    // Advance the shadow state by one accepted word, queue its results
    task automatic track_request(input logic [1:0] req, input logic [7:0] val);
        logic [29:0] tail;
        logic [4:0]  sym;
        logic [1:0]  st;
        case (req)
            bce_pkg::REQ_HRP: begin
                if (in_data || hrp_len >= HRP_CAP) begin
                    seq_fault = 1'b1;
                end else begin
                    poly_acc = polymod_step(poly_acc, {2'b00, val[7:5]});
                    hrp_lows[hrp_len[LOW_IDX_W-1:0]] = val[4:0];
                    hrp_len++;
                end
            end
            bce_pkg::REQ_DATA: begin
                flush_hrp_lows();
                poly_acc = polymod_step(poly_acc, val[4:0]);
                if (data_cnt != bce_pkg::CNT_MAX) data_cnt++;
            end
            bce_pkg::REQ_CREATE: begin
                flush_hrp_lows();
                if (seq_fault) begin
                    push_result(5'd0, 7'd0, bce_pkg::ST_SEQ_ERR, 1'b1);
                end else begin
                    tail = poly_acc;
                    repeat (6) tail = polymod_step(tail, 5'd0);
                    tail = tail ^ bce_pkg::CHK_INIT;
                    for (int i = 0; i < 6; i++) begin
                        sym = tail[25 - 5 * i +: 5];
                        push_result(sym, symbol_letter(sym), bce_pkg::ST_OK, i == 5);
                    end
                end
                clear_shadow();
            end
            default: begin
                flush_hrp_lows();
                if (seq_fault)
                    st = bce_pkg::ST_SEQ_ERR;
                else if (data_cnt < bce_pkg::MIN_DATA)
                    st = bce_pkg::ST_SHORT;
                else if (poly_acc != bce_pkg::CHK_INIT)
                    st = bce_pkg::ST_MISMATCH;
                else
                    st = bce_pkg::ST_OK;
                push_result(5'd0, 7'd0, st, 1'b1);
                clear_shadow();
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_left > 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else if (rx_stall_on) begin
                m_ready <= ($urandom_range(99) >= 20);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        result_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected: symbol %0d status %0d",
                       m_symbol, m_status);
                mismatch_count++;
            end else begin
                want = pending_words.pop_front();
                if (m_symbol !== want.symbol) begin
                    $error("symbol mismatch: expected %0d, got %0d",
                           want.symbol, m_symbol);
                    mismatch_count++;
                end
                if (m_symbol_char !== want.symbol_char) begin
                    $error("symbol_char mismatch: expected %0h, got %0h",
                           want.symbol_char, m_symbol_char);
                    mismatch_count++;
                end
                if (m_status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, m_status);
                    mismatch_count++;
                end
                if (m_last !== want.last) begin
                    $error("last mismatch: expected %0d, got %0d",
                           want.last, m_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Give up on a hung run
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word, hold it until taken, then predict
    task automatic send_word(input logic [1:0] req, input logic [7:0] val);
        if (tx_gaps_on && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_value    <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_request(req, val);
        words_sent++;
    endtask

    task automatic send_message(input byte_q_t hrp_chars, input byte_q_t data_syms,
                                input logic [1:0] finish);
        foreach (hrp_chars[i]) send_word(bce_pkg::REQ_HRP, hrp_chars[i]);
        foreach (data_syms[i]) send_word(bce_pkg::REQ_DATA, data_syms[i]);
        send_word(finish, 8'($urandom_range(255)));
    endtask

    // Create, then read back the six predicted checksum symbols
    task automatic send_create_capture(input byte_q_t hrp_chars, input byte_q_t data_syms,
                                       output logic [5:0][4:0] syms);
        int base;
        send_message(hrp_chars, data_syms, bce_pkg::REQ_CREATE);
        base = pending_words.size() - 6;
        syms = '0;
        for (int i = 0; i < 6; i++) begin
            if (base + i >= 0) syms[i] = pending_words[base + i].symbol;
        end
    endtask

    function automatic byte_q_t random_bytes(input int count);
        byte_q_t q;
        for (int i = 0; i < count; i++) q.insert(q.size(), 8'($urandom_range(255)));
        return q;
    endfunction

    // Create a checksum, then verify the message with it, corrupted at times
    task automatic send_round_trip(input byte_q_t hrp_chars, input byte_q_t data_syms,
                                   input bit corrupt);
        logic [5:0][4:0] syms;
        byte_q_t         full;
        int              pos;
        send_create_capture(hrp_chars, data_syms, syms);
        if (corrupt) begin
            pos = $urandom_range(5);
            syms[pos] = syms[pos] ^ 5'($urandom_range(1, 31));
        end
        full = data_syms;
        for (int i = 0; i < 6; i++)
            full.insert(full.size(), {3'($urandom_range(7)), syms[i]});
        send_message(hrp_chars, full, bce_pkg::REQ_VERIFY);
    endtask

    task automatic send_random_message();
        byte_q_t    hrp_chars;
        byte_q_t    data_syms;
        int         kind;
        int         hrp_n;
        int         cut;
        logic [1:0] finish;
        kind      = $urandom_range(99);
        hrp_n     = ($urandom_range(19) == 0) ? $urandom_range(9, HRP_CAP)
                                              : $urandom_range(0, 6);
        hrp_chars = random_bytes(hrp_n);
        data_syms = random_bytes($urandom_range(0, 12));
        finish    = $urandom_range(1) ? bce_pkg::REQ_CREATE : bce_pkg::REQ_VERIFY;
        if (kind < 10) begin
            // Noise: any request with any value
            repeat ($urandom_range(1, 10))
                send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
        end else if (kind < 20) begin
            // Broken: an hrp character slipped into the data part, unless cut is at the end
            cut = $urandom_range(0, data_syms.size());
            foreach (hrp_chars[i]) send_word(bce_pkg::REQ_HRP, hrp_chars[i]);
            send_word(bce_pkg::REQ_DATA, 8'($urandom_range(255)));
            foreach (data_syms[i]) begin
                if (i == cut) send_word(bce_pkg::REQ_HRP, 8'($urandom_range(255)));
                send_word(bce_pkg::REQ_DATA, data_syms[i]);
            end
            send_word(finish, 8'($urandom_range(255)));
        end else if (kind < 50) begin
            send_round_trip(hrp_chars, data_syms, $urandom_range(99) < 30);
        end else begin
            send_message(hrp_chars, data_syms, finish);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_empty_message();
        byte_q_t none;
        send_message(none, none, bce_pkg::REQ_VERIFY);
        send_message(none, none, bce_pkg::REQ_CREATE);
    endtask

    task automatic test_field_extremes();
        send_message('{8'h00, 8'hff}, '{8'h00, 8'hff, 8'he0}, bce_pkg::REQ_CREATE);
    endtask

    task automatic test_round_trip();
        byte_q_t none;
        send_round_trip('{8'h61}, none, 1'b0);
    endtask

    task automatic test_sequence_errors();
        // hrp after data, then create
        send_word(bce_pkg::REQ_DATA, 8'h15);
        send_word(bce_pkg::REQ_HRP, 8'h41);
        send_word(bce_pkg::REQ_CREATE, 8'h00);
        // hrp after data, then verify
        send_word(bce_pkg::REQ_HRP, 8'h62);
        send_word(bce_pkg::REQ_DATA, 8'h1f);
        send_word(bce_pkg::REQ_HRP, 8'h80);
        send_word(bce_pkg::REQ_VERIFY, 8'hff);
    endtask

    task automatic test_hrp_capacity();
        // Fill the store, then one character past it: longest flush walk
        send_message(random_bytes(HRP_CAP + 1), random_bytes(0), bce_pkg::REQ_VERIFY);
    endtask

    task automatic test_backpressure();
        tx_gaps_on   = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        repeat (2) send_message(random_bytes(2), random_bytes(3), bce_pkg::REQ_CREATE);
        tx_gaps_on   = 1'b1;
    endtask

    task automatic test_back_to_back();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        repeat (3) send_random_message();
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    task automatic test_random_messages();
        do
            send_random_message();
        while (words_sent < TOTAL_WORDS);
    endtask

    initial begin
        mismatch_count  = 0;
        words_sent      = 0;
        rx_hold_left    = 0;
        tx_gaps_on      = 1'b1;
        rx_stall_on     = 1'b1;
        clear_shadow();
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_req_type <= bce_pkg::REQ_HRP;
        s_value    <= 8'h00;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_message();
        test_field_extremes();
        test_round_trip();
        test_sequence_errors();
        test_hrp_capacity();
        test_backpressure();
        test_back_to_back();
        test_random_messages();

        // Drain outstanding results
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bce_pkg.sv
hdl/bce_ctrl.sv
hdl/bce_dp.sv
hdl/bech32_checksum_engine.sv
tb/tb_top.sv
